// ----- rtl/core/rss_pkg.sv -----
// Shared types, constants and key selection for the record selection sort unit.
`timescale 1ns / 1ps
package rss_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int KEY_W       = 24;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORDS);

  localparam logic [2:0] KEY_ID       = 3'd1;
  localparam logic [2:0] KEY_ENERGY   = 3'd2;
  localparam logic [2:0] KEY_COST     = 3'd3;
  localparam logic [2:0] KEY_DURATION = 3'd4;
  localparam logic [2:0] KEY_RESET    = KEY_ID;

  typedef struct packed {
    logic [15:0] record_id;
    logic [36:0] customer_number;
    logic [1:0]  charger_index;
    logic [8:0]  power_tenths_kw;
    logic [23:0] energy_mwh;
    logic [23:0] duration_seconds;
    logic [23:0] cost_cents;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic [15:0] record_id;
    logic [36:0] customer_number;
    logic [1:0]  charger_index;
    logic [8:0]  power_tenths_kw;
    logic [23:0] energy_mwh;
    logic [23:0] duration_seconds;
    logic [23:0] cost_cents;
    logic        batch_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_record_id;
    logic [36:0] out_customer_number;
    logic [1:0]  out_charger_index;
    logic [8:0]  out_power_tenths_kw;
    logic [23:0] out_energy_mwh;
    logic [23:0] out_duration_seconds;
    logic [23:0] out_cost_cents;
    logic        out_last;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic emit_valid;
    logic emit_last;
  } seq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_EMIT
  } seq_state_t;

  function automatic logic [KEY_W-1:0] key_of(rec_t r, logic [2:0] k);
    logic [KEY_W-1:0] key;
    unique case (k)
      KEY_ID:     key = {{(KEY_W-16){1'b0}}, r.record_id};
      KEY_ENERGY: key = r.energy_mwh;
      KEY_COST:   key = r.cost_cents;
      default:    key = r.duration_seconds;
    endcase
    return key;
  endfunction

  function automatic logic key_valid(logic [2:0] k);
    return (k == KEY_ID) || (k == KEY_ENERGY) || (k == KEY_COST) || (k == KEY_DURATION);
  endfunction

endpackage

// ----- rtl/core/record_selection_sort_unit.sv -----
// A load is stored while idle; after the batch end the pass at pos reads the record at pos,
// scans those after it and, if their minimum lies elsewhere, swaps it in S_SWAP_A and S_SWAP_B.
// Replay then reads one record per cycle from the RAM, through its read and result registers;
// the RAM's single read port sets the one compare per cycle of the scan.
// Reset clears the record count and sets sort_key to id; store contents stay undefined.
// The receiver cannot stall: each result is strobed for one cycle by result_valid.
`timescale 1ns / 1ps
module record_selection_sort_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  rss_pkg::in_item_t   cmd,
  input  logic                sort_key_we,
  input  logic [2:0]          sort_key_data,
  output logic                result_valid,
  output rss_pkg::out_item_t  result
);
  import rss_pkg::*;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  rec_t             mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  rec_t             mem_rdata;
  seq_status_t      status;

  rss_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_RECORDS)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  rss_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .sort_key_we  (sort_key_we),
    .sort_key_data(sort_key_data),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .status       (status)
  );

  assign busy = status.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= status.emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (status.emit_valid) begin
      result <= '{out_record_id: mem_rdata.record_id,
                  out_customer_number: mem_rdata.customer_number,
                  out_charger_index: mem_rdata.charger_index,
                  out_power_tenths_kw: mem_rdata.power_tenths_kw,
                  out_energy_mwh: mem_rdata.energy_mwh,
                  out_duration_seconds: mem_rdata.duration_seconds,
                  out_cost_cents: mem_rdata.cost_cents,
                  out_last: status.emit_last};
    end
  end

`ifndef SYNTHESIS
  // Every transfer comes from a replay read issued while the unit was busy.
  a_result_from_replay: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy, 2))
    else $error("result transfer without a replay read");

  // Leaving busy means the final record of the run follows on the next cycle.
  a_idle_ends_run: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |=> result_valid && result.out_last)
    else $error("unit went idle without a final transfer");

  // A run cannot restart so fast that a transfer follows the final one directly.
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_last |=> !result_valid)
    else $error("transfer right after the final record");
`endif

endmodule

// ----- rtl/core/rss_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/rss_seq.sv -----
// Sequencer: loads records, runs the selection sort passes for a valid key and replays the store.
`timescale 1ns / 1ps
module rss_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  rss_pkg::in_item_t         cmd,
  input  logic                      sort_key_we,
  input  logic [2:0]                sort_key_data,
  output logic                      mem_we,
  output logic [rss_pkg::IDX_W-1:0] mem_waddr,
  output rss_pkg::rec_t             mem_wdata,
  output logic [rss_pkg::IDX_W-1:0] mem_raddr,
  input  rss_pkg::rec_t             mem_rdata,
  output rss_pkg::seq_status_t      status
);
  import rss_pkg::*;

  seq_state_t       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] pos, pos_next;
  logic [CNT_W-1:0] scan, scan_next;
  logic             rd_valid, rd_valid_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;
  logic [IDX_W-1:0] best_idx;
  rec_t             best_rec;
  rec_t             pos_rec;
  logic [2:0]       sort_key;
  logic             emit_valid, emit_valid_next;
  logic             emit_last, emit_last_next;
  logic [CNT_W-1:0] load_count;
  logic             more_passes;
  rec_t             cmd_rec;

  assign cmd_rec = '{record_id: cmd.record_id, customer_number: cmd.customer_number,
                     charger_index: cmd.charger_index, power_tenths_kw: cmd.power_tenths_kw,
                     energy_mwh: cmd.energy_mwh, duration_seconds: cmd.duration_seconds,
                     cost_cents: cmd.cost_cents};

  assign load_count  = (count < MAX_CNT) ? count + CNT_W'(1) : count;
  assign more_passes = ({1'b0, pos} + (CNT_W + 1)'(2)) < {1'b0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pos        <= '0;
      scan       <= '0;
      rd_valid   <= 1'b0;
      rd_idx     <= '0;
      emit_valid <= 1'b0;
      emit_last  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pos        <= pos_next;
      scan       <= scan_next;
      rd_valid   <= rd_valid_next;
      rd_idx     <= rd_idx_next;
      emit_valid <= emit_valid_next;
      emit_last  <= emit_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_key <= KEY_RESET;
    end else if (sort_key_we) begin
      sort_key <= sort_key_data;
    end
  end

  // The first word back in a pass is the record at pos; it seeds the minimum.
  always_ff @(posedge clk) begin
    if (state == S_SCAN && rd_valid) begin
      if (rd_idx == pos[IDX_W-1:0]) begin
        pos_rec  <= mem_rdata;
        best_rec <= mem_rdata;
        best_idx <= rd_idx;
      end else if (key_of(mem_rdata, sort_key) < key_of(best_rec, sort_key)) begin
        best_rec <= mem_rdata;
        best_idx <= rd_idx;
      end
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    scan_next       = scan;
    rd_valid_next   = 1'b0;
    rd_idx_next     = rd_idx;
    emit_valid_next = 1'b0;
    emit_last_next  = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = count[IDX_W-1:0];
    mem_wdata       = cmd_rec;
    mem_raddr       = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (count < MAX_CNT) begin
            mem_we     = 1'b1;
            count_next = load_count;
          end
          if (cmd.batch_end) begin
            if (!key_valid(sort_key) || load_count < CNT_W'(2)) begin
              scan_next  = '0;
              state_next = S_EMIT;
            end else begin
              pos_next   = '0;
              state_next = S_POS;
            end
          end
        end
      end
      S_POS: begin
        mem_raddr     = pos[IDX_W-1:0];
        rd_valid_next = 1'b1;
        rd_idx_next   = pos[IDX_W-1:0];
        scan_next     = pos + CNT_W'(1);
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (scan < count) begin
          mem_raddr     = scan[IDX_W-1:0];
          rd_valid_next = 1'b1;
          rd_idx_next   = scan[IDX_W-1:0];
          scan_next     = scan + CNT_W'(1);
        end else if (!rd_valid) begin
          if (best_idx != pos[IDX_W-1:0]) begin
            state_next = S_SWAP_A;
          end else if (more_passes) begin
            pos_next   = pos + CNT_W'(1);
            state_next = S_POS;
          end else begin
            scan_next  = '0;
            state_next = S_EMIT;
          end
        end
      end
      S_SWAP_A: begin
        mem_we     = 1'b1;
        mem_waddr  = pos[IDX_W-1:0];
        mem_wdata  = best_rec;
        state_next = S_SWAP_B;
      end
      S_SWAP_B: begin
        mem_we    = 1'b1;
        mem_waddr = best_idx;
        mem_wdata = pos_rec;
        if (more_passes) begin
          pos_next   = pos + CNT_W'(1);
          state_next = S_POS;
        end else begin
          scan_next  = '0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        mem_raddr       = scan[IDX_W-1:0];
        emit_valid_next = 1'b1;
        emit_last_next  = (scan + CNT_W'(1)) == count;
        scan_next       = scan + CNT_W'(1);
        if ((scan + CNT_W'(1)) == count) begin
          count_next = '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign status = '{busy: state != S_IDLE, emit_valid: emit_valid, emit_last: emit_last};

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the record selection sort unit: load, sort by key and replay.
`timescale 1ns / 1ps
module tb_top;
  import rss_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 16;
  localparam int MAX_PRINTED   = 20;
  localparam logic [36:0] CUSTOMER_MAX = 37'd99999999999;
  // Key codes that select no field and so leave the stored order alone.
  localparam logic [2:0] OTHER_KEYS [4] = '{3'd0, 3'd5, 3'd6, 3'd7};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    cmd = '0;
  logic        sort_key_we = 1'b0;
  logic [2:0]  sort_key_data = 3'd0;
  logic        result_valid;
  out_item_t   result;

  record_selection_sort_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .sort_key_we  (sort_key_we),
    .sort_key_data(sort_key_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted store contents, record count and active key.
  rec_t        record_store [MAX_RECORDS];
  int          stored_count = 0;
  logic [2:0]  active_key = KEY_RESET;
  out_item_t   expected_records [$];

  int          mismatch_count = 0;
  int          loads_sent = 0;
  int          loads_dropped = 0;
  int          batches_done = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  logic [7:0]  keys_written = '0;
  bit          idle_enable = 1'b1;
  out_item_t   want_rec;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d records still expected",
               cycle_count, expected_records.size());
      $display("record_selection_sort_unit test failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic logic [23:0] record_key(rec_t r, logic [2:0] k);
    case (k)
      KEY_ID:     return {8'd0, r.record_id};
      KEY_ENERGY: return r.energy_mwh;
      KEY_COST:   return r.cost_cents;
      default:    return r.duration_seconds;
    endcase
  endfunction

  // Stores one accepted load; on a batch end sorts the store and queues the replay.
  task automatic predict_load(in_item_t it);
    rec_t      r;
    rec_t      held;
    out_item_t o;
    int        pos;
    int        scan;
    int        best;
    if (stored_count < MAX_RECORDS) begin
      r.record_id        = it.record_id;
      r.customer_number  = it.customer_number;
      r.charger_index    = it.charger_index;
      r.power_tenths_kw  = it.power_tenths_kw;
      r.energy_mwh       = it.energy_mwh;
      r.duration_seconds = it.duration_seconds;
      r.cost_cents       = it.cost_cents;
      record_store[stored_count] = r;
      stored_count++;
    end else begin
      loads_dropped++;
    end
    if (it.batch_end) begin
      if (active_key >= KEY_ID && active_key <= KEY_DURATION) begin
        for (pos = 0; pos + 1 < stored_count; pos++) begin
          best = pos;
          for (scan = pos + 1; scan < stored_count; scan++)
            if (record_key(record_store[scan], active_key) <
                record_key(record_store[best], active_key))
              best = scan;
          if (best != pos) begin
            held = record_store[pos];
            record_store[pos] = record_store[best];
            record_store[best] = held;
          end
        end
      end
      for (pos = 0; pos < stored_count; pos++) begin
        o.out_record_id        = record_store[pos].record_id;
        o.out_customer_number  = record_store[pos].customer_number;
        o.out_charger_index    = record_store[pos].charger_index;
        o.out_power_tenths_kw  = record_store[pos].power_tenths_kw;
        o.out_energy_mwh       = record_store[pos].energy_mwh;
        o.out_duration_seconds = record_store[pos].duration_seconds;
        o.out_cost_cents       = record_store[pos].cost_cents;
        o.out_last             = (pos + 1 == stored_count);
        expected_records.push_back(o);
      end
      stored_count = 0;
      batches_done++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      results_seen++;
      if (expected_records.size() == 0) begin
        report_mismatch("result strobed with no record expected");
      end else begin
        want_rec = expected_records.pop_front();
        check_field("record_id", result.out_record_id, want_rec.out_record_id);
        check_field("customer_number", result.out_customer_number,
                    want_rec.out_customer_number);
        check_field("charger_index", result.out_charger_index, want_rec.out_charger_index);
        check_field("power_tenths_kw", result.out_power_tenths_kw,
                    want_rec.out_power_tenths_kw);
        check_field("energy_mwh", result.out_energy_mwh, want_rec.out_energy_mwh);
        check_field("duration_seconds", result.out_duration_seconds,
                    want_rec.out_duration_seconds);
        check_field("cost_cents", result.out_cost_cents, want_rec.out_cost_cents);
        check_field("last", result.out_last, want_rec.out_last);
      end
    end
  end

  function automatic in_item_t random_record(bit narrow);
    in_item_t    it;
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    it.customer_number = 37'(wide % (64'(CUSTOMER_MAX) + 64'd1));
    it.charger_index   = 2'($urandom_range(0, 3));
    it.power_tenths_kw = 9'($urandom_range(0, 500));
    // Narrow keys make ties common, which exercises the unstable swap.
    if (narrow) begin
      it.record_id        = 16'($urandom_range(0, 3));
      it.energy_mwh       = 24'($urandom_range(0, 3));
      it.duration_seconds = 24'($urandom_range(0, 3));
      it.cost_cents       = 24'($urandom_range(0, 3));
    end else begin
      it.record_id        = 16'($urandom);
      it.energy_mwh       = 24'($urandom);
      it.duration_seconds = 24'($urandom);
      it.cost_cents       = 24'($urandom);
    end
    it.batch_end = 1'b0;
    return it;
  endfunction

  function automatic logic [2:0] pick_key();
    if ($urandom_range(0, 3) != 0)
      return 3'($urandom_range(KEY_ID, KEY_DURATION));
    return OTHER_KEYS[$urandom_range(0, 3)];
  endfunction

  // Start stays high from one load to the next unless an idle burst is taken.
  task automatic send_item(in_item_t it);
    start <= 1'b1;
    cmd   <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    loads_sent++;
    predict_load(it);
    if (idle_enable && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_batch(int count, bit narrow);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = random_record(narrow);
      it.batch_end = (i == count - 1);
      send_item(it);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sort_key(logic [2:0] k);
    sort_key_we   <= 1'b1;
    sort_key_data <= k;
    @(posedge clk);
    sort_key_we <= 1'b0;
    active_key = k;
    keys_written[k] = 1'b1;
  endtask

  // Runs on the reset key, with every field at its extremes.
  task automatic test_extremes();
    in_item_t it;
    it = '{16'hFFFF, CUSTOMER_MAX, 2'd3, 9'd500, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0};
    send_item(it);
    it = '0;
    send_item(it);
    it = '{16'h8000, 37'h10_0000_0000, 2'd1, 9'd255, 24'h800000, 24'h000001,
           24'h7FFFFF, 1'b1};
    send_item(it);
  endtask

  task automatic test_single_record();
    in_item_t it;
    wait_for_results();
    set_sort_key(KEY_ID);
    it = random_record(1'b0);
    it.batch_end = 1'b1;
    send_item(it);
  endtask

  task automatic test_each_key();
    logic [23:0] vals [4];
    in_item_t    it;
    vals = '{24'd7, 24'd7, 24'd0, 24'hFFFFFF};
    for (int k = KEY_ENERGY; k <= KEY_DURATION; k++) begin
      wait_for_results();
      set_sort_key(3'(k));
      for (int i = 0; i < 4; i++) begin
        it = random_record(1'b0);
        it.energy_mwh       = vals[i];
        it.cost_cents       = vals[(i + 1) % 4];
        it.duration_seconds = vals[(i + 2) % 4];
        it.batch_end        = (i == 3);
        send_item(it);
      end
    end
  endtask

  task automatic test_other_keys();
    in_item_t it;
    for (int j = 0; j < 4; j++) begin
      wait_for_results();
      set_sort_key(OTHER_KEYS[j]);
      it = random_record(1'b0);
      it.record_id = 16'hFFFF;
      it.energy_mwh = 24'hFFFFFF;
      send_item(it);
      it = random_record(1'b0);
      it.record_id = 16'h0000;
      it.energy_mwh = 24'h000000;
      it.batch_end = 1'b1;
      send_item(it);
    end
  endtask

  // Random batches; key changes come with a full pause until the replay is done.
  task automatic test_random_batches();
    int start_count;
    int count;
    start_count = loads_sent;
    while (loads_sent - start_count < 120) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_for_results();
        set_sort_key(pick_key());
      end
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      send_batch(count, $urandom_range(0, 2) == 0);
    end
  endtask

  // Overfills the store; the last two loads, the final one carrying the batch end, are dropped.
  task automatic test_store_full();
    wait_for_results();
    set_sort_key(3'($urandom_range(KEY_ID, KEY_DURATION)));
    send_batch(MAX_RECORDS + 2, 1'b1);
  endtask

  task automatic test_back_to_back();
    int start_count;
    idle_enable = 1'b0;
    start_count = loads_sent;
    while (loads_sent - start_count < 40)
      send_batch($urandom_range(1, 6), $urandom_range(0, 1) == 1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_single_record();
    test_each_key();
    test_other_keys();
    test_random_batches();
    test_store_full();
    test_back_to_back();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d loads in %0d batches, %0d loads dropped on a full store,",
             loads_sent, batches_done, loads_dropped);
    $display("%0d replayed records checked, key codes written %b, %0d mismatches.",
             results_seen, keys_written, mismatch_count);
    if (mismatch_count == 0) begin
      $display("record_selection_sort_unit test passed");
    end else begin
      $display("record_selection_sort_unit test failed");
    end
    $finish;
  end

endmodule
